// ===== rtl/rhws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rhws_pkg;

    // Field widths of one transaction.
    localparam int OP_W    = 2;
    localparam int KEY_W   = 64;
    localparam int PLIES_W = 10;
    localparam int LEN_W   = 16;

    // Default ring size and fixed limits.
    localparam int RING_DEPTH_DEF  = 256;
    localparam int MIN_REPEAT_DIST = 4;
    localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Search token that walks from cell to cell.
    typedef struct packed {
        logic valid;
        logic hit;
    } t_tok;

endpackage

`default_nettype wire

// ===== rtl/rhws_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rhws_cell #(
    parameter int RING_DEPTH = rhws_pkg::RING_DEPTH_DEF,
    parameter int AGE_W      = $clog2(RING_DEPTH),
    parameter int WIN_W      = $clog2(RING_DEPTH + 1)
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_wr_en,
    input  wire [rhws_pkg::KEY_W-1:0] i_wr_data,
    input  wire [rhws_pkg::KEY_W-1:0] i_key,
    input  wire [WIN_W-1:0]           i_win,
    input  wire rhws_pkg::t_tok       i_tok,
    input  wire [AGE_W-1:0]           i_age,
    output rhws_pkg::t_tok            o_tok,
    output logic [AGE_W-1:0]          o_age
);
    import rhws_pkg::*;

    logic [KEY_W-1:0] r_entry;
    t_tok             r_tok;
    t_tok             n_tok;
    logic [AGE_W-1:0] r_age;
    logic [AGE_W-1:0] n_age;
    logic             in_window;

    // The slot counts as history when its age is inside the query window.
    assign in_window = (WIN_W'(i_age) < i_win);

    always_comb begin
        n_tok.valid = i_tok.valid;
        n_tok.hit   = i_tok.hit | (in_window && (r_entry == i_key));
        if (i_age == '0) begin
            n_age = AGE_W'(RING_DEPTH - 1);
        end else begin
            n_age = i_age - AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_age <= n_age;
    end

    assign o_tok = r_tok;
    assign o_age = r_age;

endmodule

`default_nettype wire

// ===== rtl/repetition_hash_window_search_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+----------------------------------
// input    | in        | i_in_valid / o_in_stall   | i_op, i_key_hash, i_halfmoves
// output   | out       | o_out_valid / i_out_stall | o_repeats
//
// A push, a pop or an unused op never raises o_in_stall, and another can follow at once.
// A query holds o_in_stall high until its answer moves into the output register,
// so the next transaction waits while the token walks RING_DEPTH cells.
// Reset is synchronous and active low; it clears the history length and all
// control flags. Ring entries are not cleared and need not be.
// An answer waiting in a stalled output register lets pushes and pops through.

module repetition_hash_window_search_core #(
    parameter int RING_DEPTH = rhws_pkg::RING_DEPTH_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire [rhws_pkg::OP_W-1:0]    i_op,
    input  wire [rhws_pkg::KEY_W-1:0]   i_key_hash,
    input  wire [rhws_pkg::PLIES_W-1:0] i_halfmoves,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic                        o_repeats
);
    import rhws_pkg::*;

    localparam int AGE_W = $clog2(RING_DEPTH);
    localparam int WIN_W = $clog2(RING_DEPTH + 1);

    // History length and the ring slot that the next push writes.
    logic [LEN_W-1:0] r_len;
    logic [AGE_W-1:0] r_head;

    // Query context, broadcast to every cell while the token walks.
    logic [KEY_W-1:0] r_key;
    logic [WIN_W-1:0] r_win;
    logic [WIN_W-1:0] n_win;
    logic [AGE_W-1:0] r_start_age;
    logic             r_start_valid;

    // Finished answer waiting for the output register, and the output itself.
    logic r_fin_valid;
    logic r_fin_hit;
    logic r_out_valid;
    logic r_out_hit;
    logic r_busy;

    logic in_fire;
    logic push_fire;
    logic pop_fire;
    logic query_fire;
    logic out_free;
    logic fin_move;

    logic [LEN_W-1:0] len_clip;
    logic [LEN_W-1:0] win_full;

    t_tok             w_tok [0:RING_DEPTH];
    logic [AGE_W-1:0] w_age [0:RING_DEPTH];

    assign in_fire    = i_in_valid && !r_busy;
    assign push_fire  = in_fire && (i_op == OP_PUSH) && (r_len != LEN_MAX);
    assign pop_fire   = in_fire && (i_op == OP_POP) && (r_len != '0);
    assign query_fire = in_fire && (i_op == OP_QUERY);

    assign out_free = !r_out_valid || !i_out_stall;
    assign fin_move = r_fin_valid && out_free;

    // Window is the least of halfmoves, history length and ring size; a window
    // too short for a repetition is forced empty so no cell can match.
    always_comb begin
        if (r_len < LEN_W'(RING_DEPTH)) begin
            len_clip = r_len;
        end else begin
            len_clip = LEN_W'(RING_DEPTH);
        end
        if (LEN_W'(i_halfmoves) < len_clip) begin
            win_full = LEN_W'(i_halfmoves);
        end else begin
            win_full = len_clip;
        end
        if (win_full < LEN_W'(MIN_REPEAT_DIST)) begin
            n_win = '0;
        end else begin
            n_win = win_full[WIN_W-1:0];
        end
    end

    // Length and write pointer move together so the slot never needs a modulo.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_head <= '0;
        end else if (push_fire) begin
            r_len <= r_len + LEN_W'(1);
            if (r_head == AGE_W'(RING_DEPTH - 1)) begin
                r_head <= '0;
            end else begin
                r_head <= r_head + AGE_W'(1);
            end
        end else if (pop_fire) begin
            r_len <= r_len - LEN_W'(1);
            if (r_head == '0) begin
                r_head <= AGE_W'(RING_DEPTH - 1);
            end else begin
                r_head <= r_head - AGE_W'(1);
            end
        end
    end

    // The token enters at cell zero carrying that slot's age, which is the
    // distance back from the newest entry.
    always_ff @(posedge i_clk) begin
        if (query_fire) begin
            r_key <= i_key_hash;
            r_win <= n_win;
            if (r_head == '0) begin
                r_start_age <= AGE_W'(RING_DEPTH - 1);
            end else begin
                r_start_age <= r_head - AGE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_valid <= 1'b0;
        end else begin
            r_start_valid <= query_fire;
        end
    end

    assign w_tok[0].valid = r_start_valid;
    assign w_tok[0].hit   = 1'b0;
    assign w_age[0]       = r_start_age;

    // One cell per ring slot; each stores its entry and checks the passing token.
    for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
        rhws_cell #(
            .RING_DEPTH (RING_DEPTH),
            .AGE_W      (AGE_W),
            .WIN_W      (WIN_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (push_fire && (r_head == AGE_W'(k))),
            .i_wr_data (i_key_hash),
            .i_key     (r_key),
            .i_win     (r_win),
            .i_tok     (w_tok[k]),
            .i_age     (w_age[k]),
            .o_tok     (w_tok[k+1]),
            .o_age     (w_age[k+1])
        );
    end

    // The answer leaving the last cell parks here until the output is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_tok[RING_DEPTH].valid) begin
                r_fin_valid <= 1'b1;
            end else if (fin_move) begin
                r_fin_valid <= 1'b0;
            end

            if (query_fire) begin
                r_busy <= 1'b1;
            end else if (fin_move) begin
                r_busy <= 1'b0;
            end

            if (fin_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[RING_DEPTH].valid) begin
            r_fin_hit <= w_tok[RING_DEPTH].hit;
        end
        if (fin_move) begin
            r_out_hit <= r_fin_hit;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_repeats   = r_out_hit;

endmodule

`default_nettype wire
